/* hdl/hq_pkg.sv */
// Shared types and constants for the indexed max-heap priority queue.
`timescale 1ns / 1ps
`default_nettype none

package hq_pkg;

    localparam int KIND_W  = 3;
    localparam int ID_W    = 8;
    localparam int PRIO_W  = 32;
    localparam int COUNT_W = 9;
    localparam int NUM_IDS = 256;

    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_RAISE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_LOWER  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_DECIDE,
        ST_REM_TOP,
        ST_REM_LAST,
        ST_UP_CHK,
        ST_UP_PID,
        ST_UP_CMP,
        ST_DN_CHK,
        ST_DN_L,
        ST_DN_R,
        ST_DN_CMP,
        ST_FIN,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_LATCH,
        CMD_READ,
        CMD_DECIDE,
        CMD_REM_TOP,
        CMD_REM_LAST,
        CMD_UP_CHK,
        CMD_UP_PID,
        CMD_UP_CMP,
        CMD_DN_CHK,
        CMD_DN_L,
        CMD_DN_R,
        CMD_DN_CMP,
        CMD_FIN,
        CMD_LOAD_OUT
    } cmd_t;

    typedef enum logic [1:0] {
        PATH_DONE,
        PATH_UP,
        PATH_DOWN,
        PATH_REMOVE
    } path_t;

    typedef struct packed {
        path_t path;
        logic  at_root;
        logic  leaf;
        logic  move;
        logic  empty;
        logic  out_free;
    } hq_status_t;

endpackage

`default_nettype wire

/* hdl/hq_if.sv */
// Handshake channel interfaces for the request, result and configuration beats.
`timescale 1ns / 1ps
`default_nettype none

interface hq_in_if;
    import hq_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [KIND_W-1:0]        kind;
    logic [ID_W-1:0]          id;
    logic signed [PRIO_W-1:0] priority_req;
    modport source (output valid, kind, id, priority_req, input ready);
    modport sink   (input valid, kind, id, priority_req, output ready);
endinterface

interface hq_out_if;
    import hq_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic [ID_W-1:0]          result_id;
    logic signed [PRIO_W-1:0] result_priority;
    logic [COUNT_W-1:0]       element_count;
    modport source (output valid, ok, result_id, result_priority, element_count, input ready);
    modport sink   (input valid, ok, result_id, result_priority, element_count, output ready);
endinterface

interface hq_cfg_if;
    import hq_pkg::*;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] max_elements;
    modport source (output valid, max_elements, input ready);
    modport sink   (input valid, max_elements, output ready);
endinterface

`default_nettype wire

/* hdl/hq_ctrl.sv */
// Sequencer that steps the heap datapath through one operation at a time.
`timescale 1ns / 1ps
`default_nettype none

module hq_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire hq_pkg::hq_status_t status,
    output hq_pkg::cmd_t            cmd
);
    import hq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_READ;
            ST_READ:     state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                unique case (status.path)
                    PATH_UP:     state_next = ST_UP_CHK;
                    PATH_DOWN:   state_next = ST_DN_CHK;
                    PATH_REMOVE: state_next = ST_REM_TOP;
                    default:     state_next = ST_DONE;
                endcase
            end
            ST_REM_TOP:  state_next = status.empty ? ST_DONE : ST_REM_LAST;
            ST_REM_LAST: state_next = ST_DN_CHK;
            ST_UP_CHK:   state_next = status.at_root ? ST_FIN : ST_UP_PID;
            ST_UP_PID:   state_next = ST_UP_CMP;
            ST_UP_CMP:   state_next = status.move ? ST_UP_CHK : ST_FIN;
            ST_DN_CHK:   state_next = status.leaf ? ST_FIN : ST_DN_L;
            ST_DN_L:     state_next = ST_DN_R;
            ST_DN_R:     state_next = ST_DN_CMP;
            ST_DN_CMP:   state_next = status.move ? ST_DN_CHK : ST_FIN;
            ST_FIN:      state_next = ST_DONE;
            ST_DONE:     if (status.out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = CMD_NOP;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) cmd = CMD_LATCH;
            end
            ST_READ:     cmd = CMD_READ;
            ST_DECIDE:   cmd = CMD_DECIDE;
            ST_REM_TOP:  cmd = CMD_REM_TOP;
            ST_REM_LAST: cmd = CMD_REM_LAST;
            ST_UP_CHK:   cmd = CMD_UP_CHK;
            ST_UP_PID:   cmd = CMD_UP_PID;
            ST_UP_CMP:   cmd = CMD_UP_CMP;
            ST_DN_CHK:   cmd = CMD_DN_CHK;
            ST_DN_L:     cmd = CMD_DN_L;
            ST_DN_R:     cmd = CMD_DN_R;
            ST_DN_CMP:   cmd = CMD_DN_CMP;
            ST_FIN:      cmd = CMD_FIN;
            ST_DONE:     if (status.out_free) cmd = CMD_LOAD_OUT;
            default:     cmd = CMD_NOP;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/hq_dpath.sv */
// Heap datapath: slot, priority and position memories, presence flags and result register.
`timescale 1ns / 1ps
`default_nettype none

module hq_dpath #(
    parameter int CAPACITY = 256
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire hq_pkg::cmd_t                     cmd,
    output hq_pkg::hq_status_t                    status,
    input  wire logic [hq_pkg::KIND_W-1:0]        in_kind,
    input  wire logic [hq_pkg::ID_W-1:0]          in_id,
    input  wire logic signed [hq_pkg::PRIO_W-1:0] in_prio,
    input  wire logic                             cfg_we,
    input  wire logic [hq_pkg::COUNT_W-1:0]       cfg_data,
    input  wire logic                             out_ready,
    output logic                                  out_valid,
    output logic                                  out_ok,
    output logic [hq_pkg::ID_W-1:0]               out_id,
    output logic signed [hq_pkg::PRIO_W-1:0]      out_prio,
    output logic [hq_pkg::COUNT_W-1:0]            out_count
);
    import hq_pkg::*;

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int LEFT_W = SLOT_W + 2;

    function automatic logic outranks(input logic [ID_W-1:0] a_id,
                                      input logic signed [PRIO_W-1:0] a_p,
                                      input logic [ID_W-1:0] b_id,
                                      input logic signed [PRIO_W-1:0] b_p);
        return (a_p > b_p) || ((a_p == b_p) && (a_id < b_id));
    endfunction

    // Memories.
    logic [ID_W-1:0]          heap_mem [CAPACITY];
    logic signed [PRIO_W-1:0] prio_mem [NUM_IDS];
    logic [SLOT_W-1:0]        slot_mem [NUM_IDS];

    logic                     heap_we;
    logic [SLOT_W-1:0]        heap_waddr;
    logic [ID_W-1:0]          heap_wdata;
    logic [SLOT_W-1:0]        heap_raddr;
    logic [ID_W-1:0]          heap_q;
    logic                     prio_we;
    logic [ID_W-1:0]          prio_raddr;
    logic signed [PRIO_W-1:0] prio_q;
    logic                     slot_we;
    logic [ID_W-1:0]          slot_waddr;
    logic [SLOT_W-1:0]        slot_q;

    // Registers.
    logic [KIND_W-1:0]        kind_reg;
    logic [ID_W-1:0]          id_reg;
    logic signed [PRIO_W-1:0] req_reg;
    logic [COUNT_W-1:0]       maxel_reg, maxel_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [NUM_IDS-1:0]       pres_reg, pres_next;
    logic [SLOT_W-1:0]        s_reg, s_next;
    logic [ID_W-1:0]          cur_id_reg, cur_id_next;
    logic signed [PRIO_W-1:0] cur_prio_reg, cur_prio_next;
    logic [ID_W-1:0]          c_id_reg, c_id_next;
    logic signed [PRIO_W-1:0] c_prio_reg, c_prio_next;
    logic [ID_W-1:0]          r_id_reg, r_id_next;
    logic                     has_right_reg, has_right_next;
    logic                     res_ok_reg, res_ok_next;
    logic [ID_W-1:0]          res_id_reg, res_id_next;
    logic signed [PRIO_W-1:0] res_prio_reg, res_prio_next;
    logic                     out_valid_reg, out_valid_next;

    // Derived values.
    logic [LEFT_W-1:0]        left_w;
    logic [LEFT_W-1:0]        right_w;
    logic [SLOT_W-1:0]        parent;
    logic                     in_range;
    logic                     present;
    logic                     up_move;
    logic                     right_better;
    logic [ID_W-1:0]          best_id;
    logic signed [PRIO_W-1:0] best_prio;
    logic [SLOT_W-1:0]        best_slot;
    logic                     dn_move;
    path_t                    path;

    assign left_w   = LEFT_W'({s_reg, 1'b1});
    assign right_w  = left_w + LEFT_W'(1);
    assign parent   = SLOT_W'((s_reg - SLOT_W'(1)) >> 1);
    assign in_range = (COUNT_W'(id_reg) < maxel_reg) && (32'(id_reg) < 32'(CAPACITY));
    assign present  = in_range && pres_reg[id_reg];

    assign up_move      = outranks(cur_id_reg, cur_prio_reg, c_id_reg, prio_q);
    assign right_better = has_right_reg && outranks(r_id_reg, prio_q, c_id_reg, c_prio_reg);
    assign best_id      = right_better ? r_id_reg : c_id_reg;
    assign best_prio    = right_better ? prio_q : c_prio_reg;
    assign best_slot    = right_better ? SLOT_W'(right_w) : SLOT_W'(left_w);
    assign dn_move      = outranks(best_id, best_prio, cur_id_reg, cur_prio_reg);

    always_comb
    begin
        path = PATH_DONE;
        case (kind_reg)
            KIND_INSERT: if (in_range && !present && (cnt_reg < CNT_W'(CAPACITY))) path = PATH_UP;
            KIND_RAISE:  if (present && (req_reg > prio_q)) path = PATH_UP;
            KIND_LOWER:  if (present && (req_reg < prio_q)) path = PATH_DOWN;
            KIND_REMOVE: if (cnt_reg != '0) path = PATH_REMOVE;
            default:     path = PATH_DONE;
        endcase
    end

    assign status.path     = path;
    assign status.at_root  = (s_reg == '0);
    assign status.leaf     = (left_w >= LEFT_W'(cnt_reg));
    assign status.move     = (cmd == CMD_UP_CMP) ? up_move : dn_move;
    assign status.empty    = (cnt_reg == '0);
    assign status.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        maxel_next     = cfg_we ? cfg_data : maxel_reg;
        cnt_next       = cnt_reg;
        pres_next      = pres_reg;
        s_next         = s_reg;
        cur_id_next    = cur_id_reg;
        cur_prio_next  = cur_prio_reg;
        c_id_next      = c_id_reg;
        c_prio_next    = c_prio_reg;
        r_id_next      = r_id_reg;
        has_right_next = has_right_reg;
        res_ok_next    = res_ok_reg;
        res_id_next    = res_id_reg;
        res_prio_next  = res_prio_reg;
        out_valid_next = out_valid_reg && !out_ready;
        heap_we        = 1'b0;
        heap_waddr     = s_reg;
        heap_wdata     = cur_id_reg;
        heap_raddr     = '0;
        prio_we        = 1'b0;
        prio_raddr     = id_reg;
        slot_we        = 1'b0;
        slot_waddr     = cur_id_reg;
        unique case (cmd)
            CMD_LATCH:
            begin
                res_ok_next   = 1'b0;
                res_id_next   = in_id;
                res_prio_next = '0;
            end
            CMD_READ:
            begin
                prio_raddr = id_reg;
                heap_raddr = '0;
            end
            CMD_DECIDE:
            begin
                if (path != PATH_DONE)
                begin
                    res_ok_next = 1'b1;
                end
                if (kind_reg == KIND_QUERY && present)
                begin
                    res_ok_next   = 1'b1;
                    res_prio_next = prio_q;
                end
                if (path == PATH_UP || path == PATH_DOWN)
                begin
                    prio_we       = 1'b1;
                    cur_id_next   = id_reg;
                    cur_prio_next = req_reg;
                    s_next        = slot_q;
                    if (kind_reg == KIND_INSERT)
                    begin
                        s_next            = SLOT_W'(cnt_reg);
                        cnt_next          = cnt_reg + CNT_W'(1);
                        pres_next[id_reg] = 1'b1;
                    end
                end
                if (path == PATH_REMOVE)
                begin
                    res_id_next       = heap_q;
                    pres_next[heap_q] = 1'b0;
                    cnt_next          = cnt_reg - CNT_W'(1);
                    heap_raddr        = SLOT_W'(cnt_reg - CNT_W'(1));
                    prio_raddr        = heap_q;
                end
            end
            CMD_REM_TOP:
            begin
                res_prio_next = prio_q;
                cur_id_next   = heap_q;
                prio_raddr    = heap_q;
                s_next        = '0;
            end
            CMD_REM_LAST:
            begin
                cur_prio_next = prio_q;
            end
            CMD_UP_CHK:
            begin
                heap_raddr = parent;
            end
            CMD_UP_PID:
            begin
                c_id_next  = heap_q;
                prio_raddr = heap_q;
            end
            CMD_UP_CMP:
            begin
                if (up_move)
                begin
                    heap_we    = 1'b1;
                    heap_wdata = c_id_reg;
                    slot_we    = 1'b1;
                    slot_waddr = c_id_reg;
                    s_next     = parent;
                end
            end
            CMD_DN_CHK:
            begin
                heap_raddr = SLOT_W'(left_w);
            end
            CMD_DN_L:
            begin
                c_id_next      = heap_q;
                heap_raddr     = SLOT_W'(right_w);
                prio_raddr     = heap_q;
                has_right_next = (right_w < LEFT_W'(cnt_reg));
            end
            CMD_DN_R:
            begin
                c_prio_next = prio_q;
                r_id_next   = heap_q;
                prio_raddr  = heap_q;
            end
            CMD_DN_CMP:
            begin
                if (dn_move)
                begin
                    heap_we    = 1'b1;
                    heap_wdata = best_id;
                    slot_we    = 1'b1;
                    slot_waddr = best_id;
                    s_next     = best_slot;
                end
            end
            CMD_FIN:
            begin
                heap_we    = 1'b1;
                heap_wdata = cur_id_reg;
                slot_we    = 1'b1;
                slot_waddr = cur_id_reg;
            end
            CMD_LOAD_OUT:
            begin
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_mem[heap_waddr] <= heap_wdata;
        end
        heap_q <= heap_mem[heap_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (prio_we)
        begin
            prio_mem[id_reg] <= req_reg;
        end
        prio_q <= prio_mem[prio_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= s_reg;
        end
        slot_q <= slot_mem[id_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maxel_reg     <= COUNT_W'(NUM_IDS);
            cnt_reg       <= '0;
            pres_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            maxel_reg     <= maxel_next;
            cnt_reg       <= cnt_next;
            pres_reg      <= pres_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == CMD_LATCH)
        begin
            kind_reg <= in_kind;
            id_reg   <= in_id;
            req_reg  <= in_prio;
        end
        if (cmd == CMD_LOAD_OUT)
        begin
            out_ok    <= res_ok_reg;
            out_id    <= res_id_reg;
            out_prio  <= res_prio_reg;
            out_count <= COUNT_W'(cnt_reg);
        end
        s_reg         <= s_next;
        cur_id_reg    <= cur_id_next;
        cur_prio_reg  <= cur_prio_next;
        c_id_reg      <= c_id_next;
        c_prio_reg    <= c_prio_next;
        r_id_reg      <= r_id_next;
        has_right_reg <= has_right_next;
        res_ok_reg    <= res_ok_next;
        res_id_reg    <= res_id_next;
        res_prio_reg  <= res_prio_next;
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

/* hdl/indexed_max_heap_queue.sv */
// Top level of the indexed max-heap priority queue.
`timescale 1ns / 1ps
`default_nettype none

// Indexed max-priority queue over ids below both max_elements and CAPACITY. Each request
// beat carries one operation (insert, raise, lower, remove top, query) and produces exactly
// one result beat with ok, an id, a priority and the element count after the operation.
// The queue handles one operation at a time. A request that leaves the heap alone, such as
// a rejected request or a query, passes through the read, decide and done steps only. An
// insert or a raise repeats a check, a parent-id read and a comparison per level climbed,
// stops when the check finds it at the root or the comparison stops it, and then places
// the element. A lower repeats a check, a left-child read, a right-child read and a
// comparison per level descended, stops at a leaf or at the comparison, then places the
// element. Remove top fetches the top and the last element and then sifts down like a
// lower. An insert can climb all eight levels of a 256-entry heap, and removing the top of
// a full heap can sink the last element seven levels. The steps per level are set by the
// single read port of each memory, whose read data is registered, so every level needs
// one dependent read of a neighbor's id and then one of its priority. A finished result
// sits in an output register, so the next request is taken while the previous result
// waits to be collected. Presence of each id is held in flip-flops cleared at reset, so no
// clearing pass is needed and the block is ready right after reset. max_elements may be
// written only while the queue is idle; its ready is always high.
module indexed_max_heap_queue #(
    parameter int CAPACITY = 256
) (
    input  wire logic clk,
    input  wire logic rst_n,
    hq_in_if.sink     in_ch,
    hq_out_if.source  out_ch,
    hq_cfg_if.sink    cfg_ch
);
    import hq_pkg::*;

    cmd_t       cmd;
    hq_status_t status;

    assign cfg_ch.ready = 1'b1;

    // The sequencer decides which step runs each cycle.
    hq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the heap memories and carries out each step.
    hq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_kind   (in_ch.kind),
        .in_id     (in_ch.id),
        .in_prio   (in_ch.priority_req),
        .cfg_we    (cfg_ch.valid),
        .cfg_data  (cfg_ch.max_elements),
        .out_ready (out_ch.ready),
        .out_valid (out_ch.valid),
        .out_ok    (out_ch.ok),
        .out_id    (out_ch.result_id),
        .out_prio  (out_ch.result_priority),
        .out_count (out_ch.element_count)
    );

    // Only one operation is in flight, so a taken beat closes the request side.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
        else $error("request accepted while another operation is in progress");

    // The decision step follows the read step that comes after a taken beat.
    a_decide_timing: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |-> ##2 (cmd == CMD_DECIDE))
        else $error("decision step not reached two cycles after a request beat");

    // The heap never reports more elements than it has slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (32'(out_ch.element_count) <= 32'(CAPACITY)))
        else $error("element count exceeds heap capacity");

endmodule

`default_nettype wire
